@@ design/sdpq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpq_pkg
// shared types and constants of the sorted double-ended priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package sdpq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int DATA_W   = 32;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_TAKE_FRONT = 2'd1,
		OP_TAKE_REAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic front;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/sdpq_cell.sv @@
// ----------------------------------------------------------------------------
// sdpq_cell
// one slot of the sorted chain: keeps, takes the new value, or takes a neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module sdpq_cell (
	input  wire                       clk,
	input  wire sdpq_pkg::cell_ctrl_t ctrl,
	input  wire sdpq_pkg::data_t      new_value,
	input  wire                       occupied,
	input  wire                       left_keep,
	input  wire sdpq_pkg::data_t      left_value,
	input  wire sdpq_pkg::data_t      right_value,
	output logic                      keep,
	output sdpq_pkg::data_t           value
);

	sdpq_pkg::data_t value_q;
	sdpq_pkg::data_t value_d;

	// held entry stays ahead of an equal or smaller new value
	assign keep  = occupied && (value_q >= new_value);
	assign value = value_q;

	always_comb begin
		value_d = value_q;
		if (ctrl.ins && !keep) begin
			value_d = left_keep ? new_value : left_value;
		end else if (ctrl.front) begin
			value_d = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

`default_nettype wire

@@ design/sorted_double_ended_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue
// descending sorted store with insert, take-front and take-rear requests
// ----------------------------------------------------------------------------
// channel   direction  tdata                               tuser
// s_*       in         [31:0] value                        [1:0] operation
// m_*       out        [31:0] removed_value,               [1:0] status
//                      [36:32] entry_count, [39:37] zero
//
// one request per cycle while no result is stalled; a request's result appears in the output register
// on the cycle after it is accepted. the cell row updates in that same cycle,
// every cell comparing against the broadcast value; an insert or take-front shifts the affected cells by one slot.
// arst_n clears the count and the output valid; cell contents are don't-care.
// a stalled result holds s_tready low until m_tready takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_double_ended_priority_queue (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] value
	input  wire  [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // [31:0] removed_value, [36:32] entry_count
	output logic [1:0]  m_tuser   // [1:0] status
);

	sdpq_pkg::cnt_t       count_q;
	sdpq_pkg::cnt_t       count_d;
	sdpq_pkg::cell_ctrl_t ctrl;
	sdpq_pkg::data_t      new_value;
	sdpq_pkg::data_t      taken;
	sdpq_pkg::status_t    status;
	sdpq_pkg::data_t      cell_value [sdpq_pkg::CAPACITY];
	logic                 cell_keep  [sdpq_pkg::CAPACITY];
	logic [sdpq_pkg::IDX_W-1:0] rear_idx;
	logic                 accept;
	logic                 is_empty;
	logic                 is_full;

	logic                 m_tvalid_q;
	sdpq_pkg::data_t      removed_q;
	sdpq_pkg::status_t    status_q;
	logic [4:0]           entry_count_q;

	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign new_value = sdpq_pkg::data_t'(s_tdata);
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == sdpq_pkg::CNT_W'(sdpq_pkg::CAPACITY));
	assign rear_idx  = sdpq_pkg::IDX_W'(count_q - 1'b1);

	always_comb begin
		ctrl    = '0;
		count_d = count_q;
		taken   = '0;
		status  = sdpq_pkg::ST_OK;
		unique case (sdpq_pkg::op_t'(s_tuser))
			sdpq_pkg::OP_INSERT: begin
				if (is_full) begin
					status = sdpq_pkg::ST_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + 1'b1;
				end
			end
			sdpq_pkg::OP_TAKE_FRONT: begin
				if (is_empty) begin
					status = sdpq_pkg::ST_EMPTY;
				end else begin
					ctrl.front = accept;
					taken      = cell_value[0];
					count_d    = count_q - 1'b1;
				end
			end
			sdpq_pkg::OP_TAKE_REAR: begin
				if (is_empty) begin
					status = sdpq_pkg::ST_EMPTY;
				end else begin
					taken   = cell_value[rear_idx];
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				status = sdpq_pkg::ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < sdpq_pkg::CAPACITY; i++) begin : g_cell
		logic            occ;
		logic            lkeep;
		sdpq_pkg::data_t lval;
		sdpq_pkg::data_t rval;

		assign occ = (count_q > sdpq_pkg::CNT_W'(i));

		if (i == 0) begin : g_first
			assign lkeep = 1'b1;
			assign lval  = new_value;
		end else begin : g_mid
			assign lkeep = cell_keep[i-1];
			assign lval  = cell_value[i-1];
		end

		if (i == sdpq_pkg::CAPACITY - 1) begin : g_last
			assign rval = cell_value[i];
		end else begin : g_inner
			assign rval = cell_value[i+1];
		end

		sdpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_value   (new_value),
			.occupied    (occ),
			.left_keep   (lkeep),
			.left_value  (lval),
			.right_value (rval),
			.keep        (cell_keep[i]),
			.value       (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q     <= taken;
			status_q      <= status;
			entry_count_q <= 5'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, entry_count_q, removed_q};
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

@@ design/sdpq_chk.sv @@
// ----------------------------------------------------------------------------
// sdpq_chk
// port-level checks of the sorted double-ended priority queue
// ----------------------------------------------------------------------------
`default_nettype none

module sdpq_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] s_tdata,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// a failed removal reports nothing taken and an empty store
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sdpq_pkg::ST_EMPTY) |->
			(m_tdata[31:0] == '0) && (m_tdata[36:32] == '0))
		else $error("empty status with nonzero value or count");

	// a refused insert reports a full store
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sdpq_pkg::ST_FULL) |->
			(m_tdata[31:0] == '0) && (m_tdata[36:32] == 5'(sdpq_pkg::CAPACITY)))
		else $error("full status with wrong value or count");

	// no new request while a result is held back
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result stalled");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind sorted_double_ended_priority_queue sdpq_chk u_sdpq_chk (.*);

`default_nettype wire

@@ tb/sdpq_checker.sv @@
// ----------------------------------------------------------------------------
// sdpq_checker
// watches both stream channels of the sorted double-ended priority queue,
// mirrors the sorted store for every accepted request and compares each
// accepted result, field by field, with the oldest predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module sdpq_checker
	import sdpq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [31:0] s_tdata,  // [31:0] value
	input  wire [1:0]  s_tuser,  // [1:0] operation
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [39:0] m_tdata,  // [31:0] removed_value, [36:32] entry_count
	input  wire [1:0]  m_tuser,  // [1:0] status
	output int         failures,
	output int         outstanding
);

	typedef struct packed {
		data_t      removed_value;
		status_t    status;
		logic [4:0] entry_count;
	} outcome_t;

	data_t    ranked_vals [CAPACITY];
	int       held_cnt;
	outcome_t pending_results [$];
	outcome_t got;
	outcome_t want;

	// applies one request to the mirrored store and returns its outcome
	function automatic outcome_t queue_update(logic [1:0] op, data_t val);
		outcome_t res;
		int       pos;
		int       i;
		res.removed_value = '0;
		res.status        = ST_OK;
		case (op)
			OP_INSERT: begin
				if (held_cnt >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// ties go behind existing equal values
					pos = 0;
					while (pos < held_cnt && ranked_vals[pos] >= val)
						pos++;
					for (i = held_cnt; i > pos; i--)
						ranked_vals[i] = ranked_vals[i-1];
					ranked_vals[pos] = val;
					held_cnt++;
				end
			end
			OP_TAKE_FRONT: begin
				if (held_cnt == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.removed_value = ranked_vals[0];
					for (i = 1; i < held_cnt; i++)
						ranked_vals[i-1] = ranked_vals[i];
					held_cnt--;
				end
			end
			OP_TAKE_REAR: begin
				if (held_cnt == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.removed_value = ranked_vals[held_cnt-1];
					held_cnt--;
				end
			end
			default: begin
				// unused code leaves everything alone
			end
		endcase
		res.entry_count = 5'(held_cnt);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			held_cnt = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.removed_value = m_tdata[31:0];
				got.status        = status_t'(m_tuser);
				got.entry_count   = m_tdata[36:32];
				if (pending_results.size() == 0) begin
					$error("result with no request pending: removed_value %0d status %0d entry_count %0d",
						got.removed_value, got.status, got.entry_count);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (got.removed_value !== want.removed_value) begin
						$error("removed_value expected %0d got %0d",
							want.removed_value, got.removed_value);
						failures++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						failures++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count expected %0d got %0d",
							want.entry_count, got.entry_count);
						failures++;
					end
				end
				if (m_tdata[39:37] !== 3'b000) begin
					$error("tdata padding expected 0 got %0h", m_tdata[39:37]);
					failures++;
				end
			end
			// a result never belongs to a request taken at the same edge
			if (s_tvalid && s_tready)
				pending_results.push_back(queue_update(s_tuser, s_tdata));
			outstanding <= pending_results.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sorted_double_ended_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue_tb
// drives insert, take-front and take-rear requests into the queue: first
// empty-store, extreme-value, tie and full-store cases, then random runs that
// swing between filling and draining the store, under changing stall patterns
// on both channels; results are checked by sdpq_checker
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_double_ended_priority_queue_tb;
	import sdpq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam data_t      VAL_MAX   = 32'sh7fff_ffff;
	localparam data_t      VAL_MIN   = 32'sh8000_0000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [39:0] m_tdata;
	wire  [1:0]  m_tuser;
	int          failures;
	int          outstanding;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;

	always #4 clk = ~clk;

	sorted_double_ended_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sdpq_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	task automatic push_request(input logic [1:0] op, input data_t val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic run_phase(input int n_items, input int src_pct, input int snk_pct);
		int         k;
		int         bias;
		int         run_left;
		int         pick;
		logic [1:0] op;
		data_t      val;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		run_left     = 0;
		bias         = 50;
		for (k = 0; k < n_items; k++) begin
			// runs of mostly inserts or mostly removals reach full and empty
			if (run_left == 0) begin
				run_left = $urandom_range(40, 8);
				case ($urandom_range(2))
					0: bias = 85;
					1: bias = 15;
					default: bias = 50;
				endcase
			end
			run_left--;
			if ($urandom_range(99) < 3)
				op = OP_UNUSED;
			else if ($urandom_range(99) < bias)
				op = OP_INSERT;
			else if ($urandom_range(1) == 1)
				op = OP_TAKE_FRONT;
			else
				op = OP_TAKE_REAR;
			pick = $urandom_range(99);
			if (pick < 35) begin
				val = $urandom;
			end else if (pick < 65) begin
				// narrow range for many ties
				val = int'($urandom_range(8)) - 4;
			end else if (pick < 80) begin
				case ($urandom_range(3))
					0: val = VAL_MAX;
					1: val = VAL_MIN;
					2: val = '0;
					default: val = -1;
				endcase
			end else begin
				val = int'($urandom_range(2000)) - 1000;
			end
			push_request(op, val);
		end
	endtask

	initial begin
		#(8 * 400000);
		$display("sorted_double_ended_priority_queue_tb NOT OK");
		$finish;
	end

	initial begin
		int i;
		src_idle_pct = 14;
		snk_idle_pct = 59;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// removals and unused code on an empty store
		push_request(OP_TAKE_FRONT, '0);
		push_request(OP_TAKE_REAR, -1);
		push_request(OP_UNUSED, VAL_MAX);
		push_request(OP_INSERT, VAL_MAX);
		push_request(OP_INSERT, VAL_MIN);
		push_request(OP_INSERT, '0);
		push_request(OP_INSERT, -1);
		push_request(OP_INSERT, 5);
		push_request(OP_INSERT, 5);
		push_request(OP_INSERT, 32'h5555_5555);
		push_request(OP_INSERT, 32'haaaa_aaaa);
		push_request(OP_TAKE_FRONT, '0);
		push_request(OP_TAKE_REAR, '0);
		push_request(OP_UNUSED, -1);
		// fill with ties, then insert into a full store
		for (i = 0; i < 10; i++)
			push_request(OP_INSERT, (i % 2) ? 5 : -1);
		push_request(OP_INSERT, VAL_MAX);
		wait_drained();
		run_phase(534, 14, 59);
		wait_drained();
		run_phase(534, 59, 14);
		wait_drained();
		run_phase(534, 0, 0);
		wait_drained();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("sorted_double_ended_priority_queue_tb OK");
		else
			$display("sorted_double_ended_priority_queue_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
